@@ rtl/rgb_box_blur_3x3_macros.svh @@
// Assertion helpers shared by the blur block.
// Each helper takes a label, the clock, the reset, the antecedent, the consequent and the message.
`ifndef RGB_BOX_BLUR_3X3_MACROS_SVH
`define RGB_BOX_BLUR_3X3_MACROS_SVH
`ifndef ASSERT_OFF
`define RBB_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
`define RBB_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RBB_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define RBB_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

@@ rtl/rbb_pkg.sv @@
`timescale 1ns / 1ps
package rbb_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int CHANNELS   = 3;
  localparam int PIXEL_W    = SAMPLE_W * CHANNELS;
  localparam int LINE_W     = 2 * PIXEL_W;
  localparam int WIN_ROWS   = 3;
  localparam int WIN_TAPS   = 2 * WIN_ROWS;
  localparam int TAPS       = 3 * WIN_ROWS;

  // Nine 8-bit samples sum to at most 2295, which fits 12 bits.
  localparam int SUM_W       = 12;
  // floor(s / 9) == (s * 3641) >> 15 for every s below 32768.
  localparam int DIV9_RECIP  = 3641;
  localparam int DIV9_SHIFT  = 15;
  localparam int PROD_W      = 24;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PW     = 2;
  localparam int FIFO_CW     = 3;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd768;

  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [PIXEL_W-1:0]  pixel_t;
  typedef sample_t [TAPS-1:0]  taps_t;
  typedef sample_t [CHANNELS-1:0] rgb_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
    logic    last;
  } result_t;

endpackage

@@ rtl/rbb_stream_if.sv @@
`timescale 1ns / 1ps
interface rbb_pix_if import rbb_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t red_in;
  sample_t green_in;
  sample_t blue_in;
  logic    flush;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output flush, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input flush, output ready);
endinterface

interface rbb_res_if import rbb_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t red_out;
  sample_t green_out;
  sample_t blue_out;
  logic    frame_last;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_last, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input frame_last, output ready);
endinterface

@@ rtl/rgb_box_blur_3x3.sv @@
// A result passes the window stage, each lane's sum register and the output queue.
// Throughput: one pixel or flush beat per clock while the queue has a free slot,
// one result per clock while ready; the line store has one read and one write port.
// Reset is synchronous and active high; it clears counters, window and queue.
// The line stores are not cleared; there is no clearing pass after reset.
`timescale 1ns / 1ps
`include "rgb_box_blur_3x3_macros.svh"
module rgb_box_blur_3x3 import rbb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  rbb_pix_if.sink               pixels,
  rbb_res_if.source             blurred,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Column counters must hold the width itself during the drain.
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH);

  // ------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  frame_width;
  logic [HEIGHT_REG_W-1:0] frame_height;
  logic                    cfg_we;
  logic [CW-1:0]           eff_w;
  logic [RW-1:0]           eff_h;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (paddr[REG_SEL_BIT])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // A zero register acts as one; larger values saturate at the maximum.
  always_comb begin
    if (frame_width == '0) begin
      eff_w = CW'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = RW'(1);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(frame_height);
    end
  end

  // ------------------------------------------------------------------
  // Stream position. A beat is either a pixel of the frame or, once all
  // rows are in, a flush tick that pushes a zero column through the window.
  // Flush beats inside the frame and pixel beats while draining are taken
  // and dropped without a result.
  // ------------------------------------------------------------------
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] drain_count;
  logic          can_accept;
  logic          take;
  logic          draining;
  logic          step;
  logic [CW-1:0] xi;
  logic [RW-1:0] yi;
  logic          in_row;
  logic          x_first;
  logic          has_result;
  logic          is_last;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  pixel_t        pix;

  assign pixels.ready = can_accept;
  assign take     = pixels.valid && pixels.ready;
  assign draining = row_count >= eff_h;
  assign step     = take && (draining ? pixels.flush : !pixels.flush);
  assign xi       = draining ? drain_count : column_count;
  assign yi       = draining ? eff_h : row_count;
  assign in_row   = xi < eff_w;
  assign x_first  = xi == '0;
  // At the start of a row the center is the last pixel of the row before.
  assign has_result = x_first ? (yi >= RW'(2)) : (yi >= RW'(1));
  assign is_last    = draining && (xi == eff_w);
  assign rd_en    = step && in_row;
  assign rd_addr  = xi[AW-1:0];
  assign pix      = {pixels.blue_in, pixels.green_in, pixels.red_in};

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      column_count <= '0;
      row_count    <= '0;
      drain_count  <= '0;
    end else if (step) begin
      if (!draining) begin
        if (column_count == eff_w - CW'(1)) begin
          column_count <= '0;
          row_count    <= row_count + RW'(1);
          drain_count  <= '0;
        end else begin
          column_count <= column_count + CW'(1);
        end
      end else if (drain_count == eff_w) begin
        // The last flush of the frame restarts the stream.
        column_count <= '0;
        row_count    <= '0;
        drain_count  <= '0;
      end else begin
        drain_count <= drain_count + CW'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // Window stage. Both line stores share one memory word: the upper half
  // is the row two above, the lower half the row above. The stage reads
  // the word for a column one cycle and rewrites it the next. With a
  // frame one pixel wide two consecutive beats touch the same word, so the
  // word being written is forwarded to the beat that reads it.
  // ------------------------------------------------------------------
  logic              s1_valid;
  pixel_t            s1_pix;
  logic              s1_first;
  logic [2:0]        s1_mask;
  logic              s1_result;
  logic              s1_last;
  logic              s1_we;
  logic [AW-1:0]     s1_addr;
  logic              s1_byp;
  logic [LINE_W-1:0] byp_data;
  logic [LINE_W-1:0] line_q;
  logic [LINE_W-1:0] line;
  logic [LINE_W-1:0] line_wdata;
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  pixel_t            col  [WIN_ROWS];
  pixel_t            win  [WIN_TAPS];
  pixel_t            nine [TAPS];
  tag_t              s1_tag;
  rgb_t              mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_pix    <= pix;
      s1_first  <= x_first;
      s1_mask   <= {!draining && in_row, (yi >= RW'(1)) && in_row,
                    (yi >= RW'(2)) && in_row};
      s1_result <= has_result;
      s1_last   <= is_last;
      s1_we     <= !draining;
      s1_addr   <= rd_addr;
      s1_byp    <= s1_valid && s1_we && (s1_addr == rd_addr);
      byp_data  <= line_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_we) begin
      line_mem[s1_addr] <= line_wdata;
    end
    if (rd_en) begin
      line_q <= line_mem[rd_addr];
    end
  end

  assign line       = s1_byp ? byp_data : line_q;
  assign line_wdata = {line[PIXEL_W-1:0], s1_pix};

  // Neighbors outside the frame count as zero.
  always_comb begin
    col[0] = s1_mask[0] ? line[LINE_W-1:PIXEL_W] : '0;
    col[1] = s1_mask[1] ? line[PIXEL_W-1:0] : '0;
    col[2] = s1_mask[2] ? s1_pix : '0;
    for (int r = 0; r < WIN_ROWS; r++) begin
      nine[r]              = win[r];
      nine[WIN_ROWS + r]   = win[WIN_ROWS + r];
      nine[2*WIN_ROWS + r] = s1_first ? '0 : col[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int k = 0; k < WIN_TAPS; k++) begin
        win[k] <= '0;
      end
    end else if (s1_valid) begin
      for (int r = 0; r < WIN_ROWS; r++) begin
        win[r]            <= s1_first ? '0 : win[WIN_ROWS + r];
        win[WIN_ROWS + r] <= col[r];
      end
    end
  end

  // ------------------------------------------------------------------
  // One lane per color channel: sum of nine, then divide by nine.
  // ------------------------------------------------------------------
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    taps_t taps;

    always_comb begin
      for (int k = 0; k < TAPS; k++) begin
        taps[k] = nine[k][ch*SAMPLE_W +: SAMPLE_W];
      end
    end

    rbb_lane u_lane (
      .clk  (clk),
      .taps (taps),
      .mean (mean[ch])
    );
  end

  assign s1_tag = '{valid: s1_valid && s1_result, last: s1_last};

  // The merge stage packs the lane results into the output queue and
  // grants a slot to each beat that will cause a result.
  rbb_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .reserve    (step && has_result),
    .tag        (s1_tag),
    .mean       (mean),
    .can_accept (can_accept),
    .blurred    (blurred)
  );

  `RBB_ASSERT_NXT(a_cfg_restarts, clk, rst, cfg_we,
                  (column_count == '0) && (row_count == '0) && (drain_count == '0),
                  "register write did not restart the stream")
  `RBB_ASSERT_IMP(a_column_in_row, clk, rst, !draining, column_count < eff_w,
                  "column counter past the row end")
  `RBB_ASSERT_IMP(a_row_bound, clk, rst, 1'b1, row_count <= eff_h,
                  "row counter past the frame height")
  `RBB_ASSERT_IMP(a_drain_bound, clk, rst, draining, drain_count <= eff_w,
                  "drain counter past the row end")

endmodule

@@ rtl/rbb_lane.sv @@
`timescale 1ns / 1ps
module rbb_lane import rbb_pkg::*; (
  input  logic    clk,
  input  taps_t   taps,
  output sample_t mean
);

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_r;
  logic [PROD_W-1:0] prod;

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + SUM_W'(taps[k]);
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum;
  end

  // Division by nine as a multiply by the scaled reciprocal.
  assign prod = PROD_W'(sum_r) * PROD_W'(DIV9_RECIP);
  assign mean = prod[DIV9_SHIFT +: SAMPLE_W];

endmodule

@@ rtl/rbb_merge.sv @@
`timescale 1ns / 1ps
`include "rgb_box_blur_3x3_macros.svh"
module rbb_merge import rbb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic reserve,
  input  tag_t tag,
  input  rgb_t mean,
  output logic can_accept,
  rbb_res_if.source blurred
);

  tag_t                held;
  result_t             fifo [FIFO_DEPTH];
  logic [FIFO_PW-1:0]  wp;
  logic [FIFO_PW-1:0]  rp;
  logic [FIFO_CW-1:0]  fill;
  logic [FIFO_CW-1:0]  credits;
  logic                push;
  logic                pop;

  assign push = held.valid;
  assign pop  = blurred.valid && blurred.ready;

  // The tag lines up with the sum register inside each lane.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      held <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= '{red: mean[0], green: mean[1], blue: mean[2], last: held.last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rp      <= '0;
      fill    <= '0;
      credits <= '0;
    end else begin
      if (push) begin
        wp <= wp + FIFO_PW'(1);
      end
      if (pop) begin
        rp <= rp + FIFO_PW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + FIFO_CW'(1);
        2'b01:   fill <= fill - FIFO_CW'(1);
        default: fill <= fill;
      endcase
      case ({reserve, pop})
        2'b10:   credits <= credits + FIFO_CW'(1);
        2'b01:   credits <= credits - FIFO_CW'(1);
        default: credits <= credits;
      endcase
    end
  end

  // Every result in flight holds a queue slot from the beat that causes it.
  assign can_accept = credits < FIFO_CW'(FIFO_DEPTH);

  assign blurred.valid      = fill != '0;
  assign blurred.red_out    = fifo[rp].red;
  assign blurred.green_out  = fifo[rp].green;
  assign blurred.blue_out   = fifo[rp].blue;
  assign blurred.frame_last = fifo[rp].last;

  `RBB_ASSERT_IMP(a_push_has_room, clk, rst, held.valid,
                  fill < FIFO_CW'(FIFO_DEPTH), "result queue written while full")
  `RBB_ASSERT_IMP(a_fill_within_credit, clk, rst, 1'b1, fill <= credits,
                  "queue holds more results than were reserved")

endmodule
